// ===== rtl/rse_pkg.sv =====
// Shared constants, instruction codes and pipeline types for the instruction executor.
package rse_pkg;

    // Machine sizes.
    localparam int DATA_W     = 32;
    localparam int REG_COUNT  = 32;
    localparam int MEM_WORDS  = 128;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int MEM_AW     = $clog2(MEM_WORDS);

    // The clearing pass after reset covers the larger of the two stores.
    localparam int CLR_DEPTH  = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
    localparam int CLR_W      = $clog2(CLR_DEPTH + 1);

    // Configuration port.
    localparam int APB_AW     = 3;
    localparam logic [DATA_W-1:0] PC_START_RESET = 32'd40000000;
    localparam logic CFG_PC_START = 1'b0;

    // Opcodes, bits 31..26.
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_BNE   = 6'b000101;

    // Function codes, bits 5..0, for register-register operations.
    localparam logic [5:0] FN_ADD   = 6'b100000;
    localparam logic [5:0] FN_SUB   = 6'b100010;
    localparam logic [5:0] FN_AND   = 6'b100100;
    localparam logic [5:0] FN_OR    = 6'b100101;
    localparam logic [5:0] FN_XOR   = 6'b100110;

    // A register write in flight, used for operand bypass.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] idx;
        logic [DATA_W-1:0] val;
    } wb_t;

    // Per-instruction result carried down the pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] pc_after;
        logic              wr;
        logic [REG_AW-1:0] dst;
        logic [DATA_W-1:0] val;
        logic              load;
        logic              mw;
        logic              taken;
        logic              aerr;
        logic              unsup;
    } stage_t;

    // Full execute output: the result plus the data memory request.
    typedef struct packed {
        stage_t            res;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_addr;
        logic [DATA_W-1:0] mem_wdata;
    } ex_res_t;

    // Clearing pass control toward the memories.
    typedef struct packed {
        logic              active;
        logic              rf_we;
        logic [REG_AW-1:0] rf_addr;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_addr;
    } clr_ctl_t;

endpackage

// ===== rtl/risc_subset_instr_executor.sv =====
// Throughput: one instruction per cycle unless in_stall holds the input for a held result or the clearing pass.
// Operand reads, execute and write-back are pipelined with bypass, ending in the output register to the port.
// A store to data memory is done before the next instruction's load reads it.
// Reset: the program counter loads pc_start (40000000); a clearing pass then zeroes the register
// file and data memory over all 128 entries, during which in_stall is high.
// Writing pc_start through the configuration port also loads the program counter.
module risc_subset_instr_executor (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rse_pkg::APB_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Instruction channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pc_after,
    output logic        reg_written,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_written,
    output logic        branch_taken,
    output logic        address_error,
    output logic        unsupported
);

    import rse_pkg::*;

    clr_ctl_t          clr;
    logic              advance;
    logic              accept;
    logic              cfg_we;

    logic [DATA_W-1:0] pc_start_reg;
    logic [DATA_W-1:0] pc_reg;

    logic              a_valid_reg;
    logic [31:0]       a_instr_reg;
    logic [DATA_W-1:0] rf_a;
    logic [DATA_W-1:0] rf_b;
    ex_res_t           ex;

    logic              b_valid_reg;
    stage_t            b_reg;
    stage_t            b_out;
    logic [DATA_W-1:0] dmem_rdata;
    logic [DATA_W-1:0] b_wval;
    wb_t               fwd_new;
    wb_t               wb_rec_reg;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [DATA_W-1:0] dm_wdata;

    logic              out_valid_reg;
    stage_t            out_reg;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == CFG_PC_START);
    assign prdata = (paddr[APB_AW-1] == CFG_PC_START) ? pc_start_reg : '0;

    // The whole pipeline moves unless a finished result is held by the consumer.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = clr.active || !advance;
    assign accept   = in_valid && !in_stall;

    rse_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (clr)
    );

    // Register file: two copies, one for each source operand, written together.
    assign rf_we    = clr.rf_we || (advance && fwd_new.en);
    assign rf_waddr = clr.active ? clr.rf_addr : b_reg.dst;
    assign rf_wdata = clr.active ? '0 : b_wval;

    rse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_rs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (accept),
        .raddr (instr[25:21]),
        .rdata (rf_a)
    );

    rse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_rt (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (accept),
        .raddr (instr[20:16]),
        .rdata (rf_b)
    );

    // Program counter and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_start_reg <= PC_START_RESET;
            pc_reg       <= PC_START_RESET;
        end
        else if (cfg_we)
        begin
            pc_start_reg <= pwdata;
            pc_reg       <= pwdata;
        end
        else if (advance && a_valid_reg)
        begin
            pc_reg <= ex.res.pc_after;
        end
    end

    // Execute stage input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_instr_reg <= instr;
        end
    end

    rse_exec u_exec (
        .instr   (a_instr_reg),
        .pc      (pc_reg),
        .rf_a    (rf_a),
        .rf_b    (rf_b),
        .fwd_new (fwd_new),
        .fwd_old (wb_rec_reg),
        .ex      (ex)
    );

    // Data memory: stores write at the end of execute, loads read into the next stage.
    assign dm_we    = clr.mem_we || (advance && a_valid_reg && ex.mem_we);
    assign dm_waddr = clr.active ? clr.mem_addr : ex.mem_addr;
    assign dm_wdata = clr.active ? '0 : ex.mem_wdata;

    rse_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (advance),
        .raddr (ex.mem_addr),
        .rdata (dmem_rdata)
    );

    // Write-back stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            b_reg <= ex.res;
        end
    end

    // Write-back value, and the write that the execute stage must see.
    assign b_wval      = b_reg.load ? dmem_rdata : b_reg.val;
    assign fwd_new.en  = b_valid_reg && b_reg.wr;
    assign fwd_new.idx = b_reg.dst;
    assign fwd_new.val = b_wval;

    // Record of the last register write, which the operand read in flight missed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_rec_reg <= '0;
        end
        else if (advance)
        begin
            wb_rec_reg <= fwd_new;
        end
    end

    // Finished result with the loaded or computed register value filled in.
    always_comb
    begin
        b_out     = b_reg;
        b_out.val = b_wval;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            out_reg <= b_out;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pc_after      = out_reg.pc_after;
    assign reg_written   = out_reg.wr;
    assign reg_index     = out_reg.dst;
    assign reg_value     = out_reg.val;
    assign mem_written   = out_reg.mw;
    assign branch_taken  = out_reg.taken;
    assign address_error = out_reg.aerr;
    assign unsupported   = out_reg.unsup;

endmodule

// ===== rtl/rse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rse_clear.sv =====
// Clearing sequencer that zeroes the register file and data memory after reset.
module rse_clear (
    input  logic              clk,
    input  logic              rst_n,
    output rse_pkg::clr_ctl_t ctl
);

    import rse_pkg::*;

    logic [CLR_W-1:0] cnt_reg;
    logic [CLR_W-1:0] cnt_next;
    logic             active_reg;
    logic             active_next;

    // Step through one entry per cycle until the larger store is covered.
    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        if (active_reg)
        begin
            cnt_next = cnt_reg + CLR_W'(1);
            if (cnt_reg == CLR_W'(CLR_DEPTH - 1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b1;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    // Write zero into each store while the count lies inside it.
    always_comb
    begin
        ctl.active   = active_reg;
        ctl.rf_we    = active_reg && (cnt_reg < CLR_W'(REG_COUNT));
        ctl.rf_addr  = cnt_reg[REG_AW-1:0];
        ctl.mem_we   = active_reg && (cnt_reg < CLR_W'(MEM_WORDS));
        ctl.mem_addr = cnt_reg[MEM_AW-1:0];
    end

endmodule

// ===== rtl/rse_exec.sv =====
// Decode, operand bypass, ALU, address and branch logic for one instruction.
module rse_exec (
    input  logic [31:0]       instr,
    input  logic [31:0]       pc,
    input  logic [31:0]       rf_a,
    input  logic [31:0]       rf_b,
    input  rse_pkg::wb_t      fwd_new,
    input  rse_pkg::wb_t      fwd_old,
    output rse_pkg::ex_res_t  ex
);

    import rse_pkg::*;

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [DATA_W-1:0] simm;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ea;
    logic              ea_out;

    // Register zero reads zero; otherwise the newest write in flight wins.
    function automatic logic [DATA_W-1:0] operand(
        input logic [REG_AW-1:0] idx,
        input logic [DATA_W-1:0] raw,
        input wb_t               newer,
        input wb_t               older
    );
        logic [DATA_W-1:0] v;
        v = raw;
        if (idx == '0)
        begin
            v = '0;
        end
        else if (newer.en && (newer.idx == idx))
        begin
            v = newer.val;
        end
        else if (older.en && (older.idx == idx))
        begin
            v = older.val;
        end
        return v;
    endfunction

    // Instruction fields and operands.
    assign op     = instr[31:26];
    assign rs     = instr[25:21];
    assign rt     = instr[20:16];
    assign rd     = instr[15:11];
    assign fn     = instr[5:0];
    assign simm   = {{16{instr[15]}}, instr[15:0]};
    assign a      = operand(rs, rf_a, fwd_new, fwd_old);
    assign b      = operand(rt, rf_b, fwd_new, fwd_old);
    assign ea     = a + simm;
    assign ea_out = (ea >= DATA_W'(MEM_WORDS));

    // Decode and execute.
    always_comb
    begin
        ex           = '0;
        ex.mem_addr  = ea[MEM_AW-1:0];
        ex.mem_wdata = b;

        unique case (op)
            OP_RTYPE:
            begin
                ex.res.wr  = 1'b1;
                ex.res.dst = rd;
                case (fn)
                    FN_ADD:  ex.res.val = a + b;
                    FN_SUB:  ex.res.val = a - b;
                    FN_AND:  ex.res.val = a & b;
                    FN_OR:   ex.res.val = a | b;
                    FN_XOR:  ex.res.val = a ^ b;
                    default:
                    begin
                        ex.res.wr    = 1'b0;
                        ex.res.unsup = 1'b1;
                    end
                endcase
            end
            OP_LW:
            begin
                if (ea_out)
                begin
                    ex.res.aerr = 1'b1;
                end
                else
                begin
                    ex.res.wr   = 1'b1;
                    ex.res.dst  = rt;
                    ex.res.load = 1'b1;
                end
            end
            OP_SW:
            begin
                if (ea_out)
                begin
                    ex.res.aerr = 1'b1;
                end
                else
                begin
                    ex.mem_we = 1'b1;
                    ex.res.mw = 1'b1;
                end
            end
            OP_ADDI:
            begin
                ex.res.wr  = 1'b1;
                ex.res.dst = rt;
                ex.res.val = ea;
            end
            OP_BEQ:  ex.res.taken = (a == b);
            OP_BNE:  ex.res.taken = (a != b);
            default: ex.res.unsup = 1'b1;
        endcase

        // A write to register zero is dropped and reports nothing.
        if (ex.res.wr && (ex.res.dst == '0))
        begin
            ex.res.wr = 1'b0;
        end
        if (!ex.res.wr)
        begin
            ex.res.dst  = '0;
            ex.res.val  = '0;
            ex.res.load = 1'b0;
        end

        // Next program counter.
        ex.res.pc_after = ex.res.taken ? (pc + simm) : (pc + DATA_W'(1));
    end

endmodule

// ===== rtl/rse_checker.sv =====
// Port-level checks for the instruction executor, bound to the top level.
module rse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pc_after,
    input logic        reg_written,
    input logic [4:0]  reg_index,
    input logic [31:0] reg_value,
    input logic        mem_written,
    input logic        branch_taken,
    input logic        address_error,
    input logic        unsupported
);

    // A held result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pc_after) && $stable(reg_value))
        else $error("result changed while stalled");

    // With the consumer not stalling meanwhile, an instruction transfer leads to a valid result on the port.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing after instruction transfer");

    // A faulting or unknown instruction writes nothing.
    a_no_write_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (address_error || unsupported) |-> !reg_written && !mem_written)
        else $error("write reported for a faulting instruction");

    // A register write names a nonzero register; without one the write fields are zero.
    a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reg_written && (reg_index != 5'd0) && !mem_written && !branch_taken)
                   || (!reg_written && (reg_index == 5'd0) && (reg_value == 32'd0)))
        else $error("inconsistent register write fields");

endmodule

bind risc_subset_instr_executor rse_checker u_rse_checker (.*);

// ===== tb/instr_result_checker.sv =====
// Result checker for the instruction executor: mirrors its state, predicts every result and compares.
`timescale 1ns / 1ps
module instr_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port, watched for writes.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rse_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    // Instruction channel.
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [31:0]                instr,
    // Result channel.
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [31:0]                pc_after,
    input  logic                       reg_written,
    input  logic [4:0]                 reg_index,
    input  logic [31:0]                reg_value,
    input  logic                       mem_written,
    input  logic                       branch_taken,
    input  logic                       address_error,
    input  logic                       unsupported,
    // Status toward the test top.
    output int                         fail_count,
    output int                         pending
);

    import rse_pkg::*;

    localparam logic [APB_AW-1:0] PC_START_ADDR = APB_AW'(4 * CFG_PC_START);

    // One retired instruction as seen on the result channel.
    typedef struct packed {
        logic [DATA_W-1:0] pc_after;
        logic              reg_written;
        logic [REG_AW-1:0] reg_index;
        logic [DATA_W-1:0] reg_value;
        logic              mem_written;
        logic              branch_taken;
        logic              address_error;
        logic              unsupported;
    } exec_result_t;

    // Architectural state kept alongside the block.
    logic [DATA_W-1:0] gpr [REG_COUNT];
    logic [DATA_W-1:0] dmem [MEM_WORDS];
    logic [DATA_W-1:0] pc_q;

    exec_result_t predicted_results [$];
    int errors = 0;

    // Executes one instruction on the mirrored state and returns what the block should report.
    function automatic exec_result_t execute_instr(input logic [DATA_W-1:0] w);
        exec_result_t      r;
        logic [5:0]        op;
        logic [5:0]        fn;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [REG_AW-1:0] rd;
        logic [DATA_W-1:0] simm;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] ea;
        logic [DATA_W-1:0] next_pc;
        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        fn   = w[5:0];
        simm = {{16{w[15]}}, w[15:0]};
        a    = (rs == '0) ? '0 : gpr[rs];
        b    = (rt == '0) ? '0 : gpr[rt];
        r    = '0;
        next_pc = pc_q + DATA_W'(1);

        case (op)
            OP_RTYPE:
            begin
                r.reg_index   = rd;
                r.reg_written = 1'b1;
                case (fn)
                    FN_ADD:  r.reg_value = a + b;
                    FN_SUB:  r.reg_value = a - b;
                    FN_AND:  r.reg_value = a & b;
                    FN_OR:   r.reg_value = a | b;
                    FN_XOR:  r.reg_value = a ^ b;
                    default:
                    begin
                        r.reg_written = 1'b0;
                        r.unsupported = 1'b1;
                    end
                endcase
            end
            OP_LW:
            begin
                ea = a + simm;
                if (ea >= DATA_W'(MEM_WORDS))
                begin
                    r.address_error = 1'b1;
                end
                else
                begin
                    r.reg_index   = rt;
                    r.reg_value   = dmem[ea[MEM_AW-1:0]];
                    r.reg_written = 1'b1;
                end
            end
            OP_SW:
            begin
                ea = a + simm;
                if (ea >= DATA_W'(MEM_WORDS))
                begin
                    r.address_error = 1'b1;
                end
                else
                begin
                    dmem[ea[MEM_AW-1:0]] = b;
                    r.mem_written = 1'b1;
                end
            end
            OP_ADDI:
            begin
                r.reg_index   = rt;
                r.reg_value   = a + simm;
                r.reg_written = 1'b1;
            end
            OP_BEQ:  r.branch_taken = (a == b);
            OP_BNE:  r.branch_taken = (a != b);
            default: r.unsupported = 1'b1;
        endcase

        // A write to register zero is dropped and reported as no write at all.
        if (r.reg_written && r.reg_index == '0)
        begin
            r.reg_written = 1'b0;
        end
        if (r.reg_written)
        begin
            gpr[r.reg_index] = r.reg_value;
        end
        else
        begin
            r.reg_index = '0;
            r.reg_value = '0;
        end

        if (r.branch_taken)
        begin
            next_pc = pc_q + simm;
        end
        pc_q       = next_pc;
        r.pc_after = pc_q;
        return r;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Track configuration writes, compare result transfers, predict instruction transfers.
    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t got;
        exec_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                gpr[i] = '0;
            end
            for (int i = 0; i < MEM_WORDS; i++)
            begin
                dmem[i] = '0;
            end
            pc_q = PC_START_RESET;
            predicted_results.delete();
            pending <= 0;
        end
        else
        begin
            // Writing pc_start also reloads the program counter.
            if (psel && penable && pwrite && pready && paddr == PC_START_ADDR)
            begin
                pc_q = pwdata;
            end

            if (out_valid && !out_stall)
            begin
                got = {pc_after, reg_written, reg_index, reg_value,
                       mem_written, branch_taken, address_error, unsupported};
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with nothing predicted, actual pc_after %h",
                             $time, pc_after);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("pc_after", want.pc_after, got.pc_after);
                    check_field("reg_written", DATA_W'(want.reg_written),
                                DATA_W'(got.reg_written));
                    check_field("reg_index", DATA_W'(want.reg_index), DATA_W'(got.reg_index));
                    check_field("reg_value", want.reg_value, got.reg_value);
                    check_field("mem_written", DATA_W'(want.mem_written),
                                DATA_W'(got.mem_written));
                    check_field("branch_taken", DATA_W'(want.branch_taken),
                                DATA_W'(got.branch_taken));
                    check_field("address_error", DATA_W'(want.address_error),
                                DATA_W'(got.address_error));
                    check_field("unsupported", DATA_W'(want.unsupported),
                                DATA_W'(got.unsupported));
                end
            end

            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(execute_instr(instr));
            end
            pending <= predicted_results.size();
        end
        fail_count <= errors;
    end

endmodule

// ===== tb/risc_subset_instr_executor_test.sv =====
// Test top for the instruction executor: reset, configuration, instruction stimulus and verdict.
`timescale 1ns / 1ps
module risc_subset_instr_executor_test;

    import rse_pkg::*;

    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 215;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam logic [APB_AW-1:0] PC_START_ADDR = APB_AW'(4 * CFG_PC_START);

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [31:0]       instr    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [31:0]       pc_after;
    logic              reg_written;
    logic [4:0]        reg_index;
    logic [31:0]       reg_value;
    logic              mem_written;
    logic              branch_taken;
    logic              address_error;
    logic              unsupported;

    int   fail_count;
    int   pending;
    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    int   long_hold_count = 0;

    risc_subset_instr_executor i_dut (.*);

    instr_result_checker i_result_check (.*);

    always #1 clk = ~clk;

    // Result side: random stall, or a long hold-off each time one more is requested.
    initial
    begin : result_sink
        int hold_left;
        int holds_started;
        hold_left     = 0;
        holds_started = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_count != holds_started)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                holds_started = long_hold_count;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("risc_subset_instr_executor test failed");
        $finish;
    end

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] shamt,
                                          input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, shamt, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Mostly well-formed instructions with small bases so memory accesses hit, plus noise.
    function automatic logic [31:0] random_instr();
        int unsigned pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [15:0] imm;
        pick = $urandom_range(99);
        rs   = 5'($urandom);
        rt   = 5'($urandom);
        rd   = 5'($urandom);
        if (pick < 15)
        begin
            // Small constants give later loads and stores usable base registers.
            if ($urandom_range(3) != 0)
            begin
                rs = '0;
            end
            imm = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(140));
            return enc_i(OP_ADDI, rs, rt, imm);
        end
        if (pick < 35)
        begin
            case ($urandom_range(4))
                0:       fn = FN_ADD;
                1:       fn = FN_SUB;
                2:       fn = FN_AND;
                3:       fn = FN_OR;
                default: fn = FN_XOR;
            endcase
            return enc_r(rs, rt, rd, 5'($urandom), fn);
        end
        if (pick < 65)
        begin
            op = (pick < 50) ? OP_LW : OP_SW;
            if ($urandom_range(1) == 0)
            begin
                rs  = '0;
                imm = 16'($urandom_range(MEM_WORDS - 1));
            end
            else
            begin
                imm = 16'($urandom_range(MEM_WORDS + 8) - 4);
            end
            if ($urandom_range(9) == 0)
            begin
                imm = 16'($urandom);
            end
            return enc_i(op, rs, rt, imm);
        end
        if (pick < 80)
        begin
            if ($urandom_range(2) == 0)
            begin
                rt = rs;
            end
            op = ($urandom_range(1) == 0) ? OP_BEQ : OP_BNE;
            return enc_i(op, rs, rt, 16'($urandom));
        end
        if (pick < 88)
        begin
            return enc_r(rs, rt, rd, 5'($urandom), 6'($urandom));
        end
        if (pick < 94)
        begin
            do
                op = 6'($urandom_range(63));
            while (op == OP_RTYPE || op == OP_LW || op == OP_SW || op == OP_ADDI ||
                   op == OP_BEQ || op == OP_BNE);
            return enc_i(op, rs, rt, 16'($urandom));
        end
        return $urandom;
    endfunction

    // Offers one instruction after a random idle stretch and returns at its transfer.
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instr    <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then the access cycle that completes on pready.
    task automatic write_pc_start(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PC_START_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] directed_words [$];
        logic [31:0] phase_pc;
        directed_words = {
            enc_i(OP_ADDI, 5'd0, 5'd1, 16'd5),
            enc_i(OP_ADDI, 5'd0, 5'd2, 16'hFFFF),
            enc_i(OP_ADDI, 5'd1, 5'd0, 16'd7),        // write to register zero
            enc_r(5'd1, 5'd2, 5'd3, 5'd31, FN_ADD),   // shift amount set but ignored
            enc_r(5'd1, 5'd2, 5'd4, 5'd0, FN_SUB),
            enc_r(5'd2, 5'd1, 5'd5, 5'd0, FN_AND),
            enc_r(5'd2, 5'd1, 5'd6, 5'd0, FN_OR),
            enc_r(5'd2, 5'd1, 5'd7, 5'd0, FN_XOR),
            enc_r(5'd1, 5'd2, 5'd8, 5'd0, 6'h3F),     // unknown function code
            32'h0000_0000,
            enc_i(6'h3F, 5'd31, 5'd31, 16'hFFFF),     // unknown opcode
            enc_i(OP_SW, 5'd1, 5'd2, 16'd122),        // top word of memory
            enc_i(OP_LW, 5'd1, 5'd8, 16'd122),
            enc_i(OP_SW, 5'd0, 5'd2, 16'd0),
            enc_i(OP_LW, 5'd0, 5'd9, 16'd0),
            enc_i(OP_LW, 5'd1, 5'd10, 16'd123),       // one past the end
            enc_i(OP_SW, 5'd1, 5'd2, 16'hFFFA),       // negative address
            enc_i(OP_LW, 5'd2, 5'd11, 16'd0),         // huge base
            enc_i(OP_LW, 5'd0, 5'd0, 16'd0),          // load into register zero
            enc_i(OP_BEQ, 5'd1, 5'd1, 16'h7FFF),
            enc_i(OP_BEQ, 5'd1, 5'd2, 16'hFFFF),
            enc_i(OP_BNE, 5'd1, 5'd2, 16'h8000),
            enc_i(OP_BNE, 5'd3, 5'd3, 16'h0001),
            32'hFFFF_FFFF,
            enc_i(OP_ADDI, 5'd2, 5'd31, 16'h7FFF)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: the first few run from the reset value of the counter.
        for (int i = 0; i < 3; i++)
        begin
            send_word(directed_words[i]);
        end
        wait_for_drain();
        write_pc_start(32'hFFFF_FFFD);
        for (int i = 3; i < directed_words.size(); i++)
        begin
            send_word(directed_words[i]);
        end

        // Random phases, each with its own start counter and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_for_drain();
            case (p)
                0:       phase_pc = 32'h0000_0000;
                1:       phase_pc = 32'hFFFF_FFFF;
                3:       phase_pc = PC_START_RESET;
                4:       phase_pc = 32'h8000_0000;
                5:       phase_pc = 32'h7FFF_FFFF;
                7:       phase_pc = 32'h0000_0001;
                default: phase_pc = $urandom;
            endcase
            write_pc_start(phase_pc);
            send_idle_pct  = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 12 : 0;
            recv_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 12 : 0;
            if (p % 4 == 0)
            begin
                long_hold_count++;
            end
            repeat (PHASE_ITEMS) send_word(random_instr());
        end

        wait_for_drain();
        if (fail_count == 0)
        begin
            $display("risc_subset_instr_executor test passed");
        end
        else
        begin
            $display("risc_subset_instr_executor test failed");
        end
        $finish;
    end

endmodule
